FILE: src/sync_length_packet_deframer_top_macros.svh
// Assertion macros used by the deframer checker
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_TOP_MACROS_SVH

// condition must hold at every edge out of reset
`define SLPD_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("slpd check failed");

// pre at one edge implies post at the next
`define SLPD_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("slpd check failed");

`endif

FILE: src/slpd_pkg.sv
// Types and constants for the sync/length packet deframer
`default_nettype none
package slpd_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hFF;
	localparam logic [7:0] SYNC_SECOND = 8'hFA;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_CMD   = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] command;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic       has_payload;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

endpackage
`default_nettype wire

FILE: src/sync_length_packet_deframer_top.sv
// Top level of the sync/length packet deframer
//
//  channel | dir | fields
//  s_*     | in  | tdata[7:0] rx_byte
//  m_*     | out | tdata command, payload_length, payload_byte, byte_index;
//          |     | tuser has_payload; tlast last
//
// One byte per cycle sustained while the output takes results. A byte taken
// is held in the input register, and the state machine loads the result
// register from it, so a result passes both registers before it is offered.
// Reset returns the framer to hunting for the first sync byte.
// A stalled output blocks only bytes that produce a result.
`default_nettype none
module sync_length_packet_deframer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] command, [15:8] payload_length,
	                                    // [23:16] payload_byte, [31:24] byte_index
	output logic             m_tuser,   // [0] has_payload
	output logic             m_tlast
);

	slpd_pkg::stage_t  stage;
	slpd_pkg::result_t result;
	logic              take;

	slpd_ingress u_ingress (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.take     (take),
		.stage    (stage)
	);

	slpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.take      (take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = {result.byte_index, result.payload_byte,
		result.payload_length, result.command};
	assign m_tuser = result.has_payload;
	assign m_tlast = result.last;

endmodule
`default_nettype wire

FILE: src/slpd_ingress.sv
// Input register stage of the deframer
`default_nettype none
module slpd_ingress (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_data,
	input  wire logic          take,
	output slpd_pkg::stage_t   stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_data;
		end
	end

	assign stage.valid   = valid_s1;
	assign stage.rx_byte = byte_s1;

endmodule
`default_nettype wire

FILE: src/slpd_parser.sv
// Framing state machine and result register of the deframer
`default_nettype none
module slpd_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire slpd_pkg::stage_t stage,
	output logic               take,
	output logic               out_valid,
	input  wire logic          out_ready,
	output slpd_pkg::result_t  result
);

	slpd_pkg::phase_t  phase_q, phase_d;
	logic [7:0]        len_q, cmd_q, cnt_q;
	logic              emit;
	logic              is_last;
	logic              slot_free;
	slpd_pkg::result_t res_d;
	slpd_pkg::result_t res_q;
	logic              valid_q;

	assign is_last = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len_q};

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			slpd_pkg::PH_SYNC2: begin
				if (stage.rx_byte == slpd_pkg::SYNC_SECOND)
					phase_d = slpd_pkg::PH_LEN;
				else if (stage.rx_byte == slpd_pkg::SYNC_FIRST)
					phase_d = slpd_pkg::PH_SYNC2;
				else
					phase_d = slpd_pkg::PH_HUNT;
			end
			slpd_pkg::PH_LEN: begin
				phase_d = slpd_pkg::PH_CMD;
			end
			slpd_pkg::PH_CMD: begin
				phase_d = (len_q == 8'd0) ? slpd_pkg::PH_HUNT : slpd_pkg::PH_DATA;
			end
			slpd_pkg::PH_DATA: begin
				phase_d = is_last ? slpd_pkg::PH_HUNT : slpd_pkg::PH_DATA;
			end
			default: begin
				phase_d = (stage.rx_byte == slpd_pkg::SYNC_FIRST) ?
					slpd_pkg::PH_SYNC2 : slpd_pkg::PH_HUNT;
			end
		endcase
	end

	always_comb begin
		emit                 = 1'b0;
		res_d.command        = cmd_q;
		res_d.payload_length = len_q;
		res_d.payload_byte   = 8'd0;
		res_d.byte_index     = 8'd0;
		res_d.has_payload    = 1'b0;
		res_d.last           = 1'b0;
		case (phase_q)
			slpd_pkg::PH_CMD: begin
				// empty packet notice
				emit          = (len_q == 8'd0);
				res_d.command = stage.rx_byte;
				res_d.last    = 1'b1;
			end
			slpd_pkg::PH_DATA: begin
				emit              = 1'b1;
				res_d.payload_byte = stage.rx_byte;
				res_d.byte_index  = cnt_q;
				res_d.has_payload = 1'b1;
				res_d.last        = is_last;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign slot_free = !valid_q || out_ready;
	assign take      = stage.valid && (!emit || slot_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slpd_pkg::PH_HUNT;
			len_q   <= 8'd0;
			cmd_q   <= 8'd0;
			cnt_q   <= 8'd0;
		end else if (take) begin
			phase_q <= phase_d;
			case (phase_q)
				slpd_pkg::PH_LEN: begin
					len_q <= stage.rx_byte;
				end
				slpd_pkg::PH_CMD: begin
					cmd_q <= stage.rx_byte;
					cnt_q <= 8'd0;
				end
				slpd_pkg::PH_DATA: begin
					cnt_q <= cnt_q + 8'd1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take && emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign result    = res_q;

endmodule
`default_nettype wire

FILE: src/slpd_checker.sv
// Port-level checker for the deframer, bound to the top level
`default_nettype none
`include "sync_length_packet_deframer_top_macros.svh"
module slpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast
);

	`SLPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
	`SLPD_ASSERT_ALWAYS(a_empty_notice, (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[31:8] == 24'd0))
	`SLPD_ASSERT_ALWAYS(a_last_mark, (m_tvalid && m_tuser) |-> (m_tlast == (m_tdata[31:24] + 9'd1 >= m_tdata[15:8])))
	`SLPD_ASSERT_ALWAYS(a_index_range, (m_tvalid && m_tuser) |-> (m_tdata[31:24] < m_tdata[15:8]))

endmodule

bind sync_length_packet_deframer_top slpd_checker u_slpd_checker (.*);
`default_nettype wire
